// ----- sv/stack_register_vm_execute_unit_defines.svh -----
// assertion macros for the stack register vm execute unit
`ifndef STACK_REGISTER_VM_EXECUTE_UNIT_DEFINES_SVH
`define STACK_REGISTER_VM_EXECUTE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication on aclk, disabled in reset
`define SVM_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("svm assertion failed");
// next-cycle implication on aclk, disabled in reset
`define SVM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("svm assertion failed");
`else
`define SVM_ASSERT_IMPL(name, ante, cons)
`define SVM_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ----- sv/svm_pkg.sv -----
// shared constants, opcodes and controller/datapath interface types
package svm_pkg;

    localparam int unsigned DATA_W   = 64;
    localparam int unsigned OP_W     = 5;
    localparam int unsigned PC_W     = 2;
    localparam int unsigned SEL_W    = 5;
    localparam int unsigned EP_W     = 16;
    localparam int unsigned RF_SLOTS = 20;

    // opcodes
    localparam logic [OP_W-1:0] OP_DEREF = 5'd0;
    localparam logic [OP_W-1:0] OP_JMP   = 5'd1;
    localparam logic [OP_W-1:0] OP_NOP   = 5'd2;
    localparam logic [OP_W-1:0] OP_JN    = 5'd3;
    localparam logic [OP_W-1:0] OP_PUSH  = 5'd4;
    localparam logic [OP_W-1:0] OP_POP   = 5'd5;
    localparam logic [OP_W-1:0] OP_MOV   = 5'd6;
    localparam logic [OP_W-1:0] OP_EXIT  = 5'd7;
    localparam logic [OP_W-1:0] OP_ADD   = 5'd8;
    localparam logic [OP_W-1:0] OP_SUB   = 5'd9;
    localparam logic [OP_W-1:0] OP_DIV   = 5'd10;
    localparam logic [OP_W-1:0] OP_MUL   = 5'd11;
    localparam logic [OP_W-1:0] OP_REM   = 5'd12;
    localparam logic [OP_W-1:0] OP_AND   = 5'd13;
    localparam logic [OP_W-1:0] OP_OR    = 5'd14;
    localparam logic [OP_W-1:0] OP_XOR   = 5'd15;
    localparam logic [OP_W-1:0] OP_NOT   = 5'd16;
    localparam logic [OP_W-1:0] OP_CMP   = 5'd17;
    localparam logic [OP_W-1:0] OP_CMPB  = 5'd18;

    // operand counts
    localparam logic [PC_W-1:0] PC_STACK = 2'd0;
    localparam logic [PC_W-1:0] PC_ONE   = 2'd1;
    localparam logic [PC_W-1:0] PC_TWO   = 2'd2;

    // operand selectors above the register range
    localparam logic [SEL_W-1:0] SEL_SP  = 5'd20;
    localparam logic [SEL_W-1:0] SEL_BP  = 5'd21;
    localparam logic [SEL_W-1:0] SEL_IMM = 5'd22;

    typedef enum logic [1:0] {ADDR_SP, ADDR_SP1, ADDR_RDATA, ADDR_X} addr_sel_t;
    typedef enum logic [1:0] {WD_X, WD_RDATA, WD_ALU} wdata_sel_t;
    typedef enum logic [1:0] {OW_RDATA, OW_Y, OW_ALU} opw_sel_t;
    typedef enum logic [1:0] {MUL_NONE, MUL_LL, MUL_LH, MUL_HL} mul_step_t;

    typedef struct packed {
        logic       ld_instr;
        logic       clr_fault;
        logic       ld_x_op1;
        logic       ld_y_op2;
        logic       ld_x_rdata;
        logic       ld_y_rdata;
        logic       mem_rd;
        logic       rd_fault_en;
        addr_sel_t  rd_addr;
        logic       mem_wr;
        addr_sel_t  wr_addr;
        wdata_sel_t wr_data;
        logic       sp_dec;
        logic       sp_inc;
        logic       opw;
        opw_sel_t   opw_data;
        logic       jump;
        logic       ip_inc;
        logic       set_halt;
        logic       div_start;
        mul_step_t  mul_step;
        logic       alu_wb;
        logic       ld_out;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic halted;
        logic cr_zero;
        logic y_zero;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

// ----- sv/stack_register_vm_execute_unit.sv -----
// top level of the stack/register vm execute unit
// result loaded once the micro-steps finish; once halted only the top-of-stack read is done,
// divide and remainder by a nonzero divisor wait on the divider (one quotient bit per cycle)
// a new transfer is taken the cycle after the result is loaded into the output register
// reset is synchronous active low; afterwards the stack is swept to zero one word per
// cycle with s_ready low; entry point writes are taken throughout
`include "stack_register_vm_execute_unit_defines.svh"

module stack_register_vm_execute_unit #(
    parameter int STACK_DEPTH = 1024,
    parameter int REG_COUNT   = 20,
    parameter int IP_INDEX    = 0,
    parameter int CR_INDEX    = 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [svm_pkg::EP_W-1:0]      cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [svm_pkg::OP_W-1:0]      s_op,
    input  logic [svm_pkg::PC_W-1:0]      s_param_count,
    input  logic [svm_pkg::SEL_W-1:0]     s_first_reg,
    input  logic [svm_pkg::DATA_W-1:0]    s_first_imm,
    input  logic [svm_pkg::SEL_W-1:0]     s_second_reg,
    input  logic [svm_pkg::DATA_W-1:0]    s_second_imm,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [svm_pkg::DATA_W-1:0]    m_next_ip,
    output logic [svm_pkg::DATA_W-1:0]    m_stack_index,
    output logic [svm_pkg::DATA_W-1:0]    m_top_value,
    output logic                          m_halted,
    output logic                          m_fault
);

    svm_pkg::cmd_t    cmd;
    svm_pkg::status_t status;

    svm_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_param_count (s_param_count),
        .status        (status),
        .cmd           (cmd)
    );

    svm_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .REG_COUNT   (REG_COUNT),
        .IP_INDEX    (IP_INDEX),
        .CR_INDEX    (CR_INDEX)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_op          (s_op),
        .s_first_reg   (s_first_reg),
        .s_first_imm   (s_first_imm),
        .s_second_reg  (s_second_reg),
        .s_second_imm  (s_second_imm),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .cmd           (cmd),
        .status        (status),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_next_ip     (m_next_ip),
        .m_stack_index (m_stack_index),
        .m_top_value   (m_top_value),
        .m_halted      (m_halted),
        .m_fault       (m_fault)
    );

    // checks
    `SVM_ASSERT_NEXT(a_one_item_in_flight, s_valid && s_ready, !s_ready)
    `SVM_ASSERT_IMPL(a_no_transfer_while_clearing, !status.clear_done, !s_ready)
    `SVM_ASSERT_NEXT(a_halt_sticky, status.halted, status.halted)
    `SVM_ASSERT_NEXT(a_load_shows_result, cmd.ld_out, m_valid)

endmodule

// ----- sv/svm_div.sv -----
// signed 64-bit restoring divider, one quotient bit per cycle
module svm_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [svm_pkg::DATA_W-1:0]   dividend,
    input  logic [svm_pkg::DATA_W-1:0]   divisor,
    output logic                         done,
    output logic [svm_pkg::DATA_W-1:0]   quotient,
    output logic [svm_pkg::DATA_W-1:0]   remainder
);

    localparam int unsigned W  = svm_pkg::DATA_W;
    localparam int unsigned CW = $clog2(W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  den_reg;
    logic          neg_q_reg;
    logic          neg_r_reg;

    logic [W:0]    shifted;
    logic [W:0]    diff;

    // one shift and trial subtract
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // magnitudes and partial results
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg   <= dividend[W-1] ? (~dividend + W'(1)) : dividend;
            den_reg   <= divisor[W-1] ? (~divisor + W'(1)) : divisor;
            rem_reg   <= '0;
            neg_q_reg <= dividend[W-1] ^ divisor[W-1];
            neg_r_reg <= dividend[W-1];
        end else if (busy_reg) begin
            if (!diff[W]) begin
                rem_reg <= diff[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    // sign fix-up
    assign quotient  = neg_q_reg ? (~quo_reg + W'(1)) : quo_reg;
    assign remainder = neg_r_reg ? (~rem_reg + W'(1)) : rem_reg;
    assign done      = done_reg;

endmodule

// ----- sv/svm_dp.sv -----
// datapath: register file, stack memory, pointers, alu and result register
module svm_dp #(
    parameter int STACK_DEPTH = 1024,
    parameter int REG_COUNT   = 20,
    parameter int IP_INDEX    = 0,
    parameter int CR_INDEX    = 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [svm_pkg::OP_W-1:0]      s_op,
    input  logic [svm_pkg::SEL_W-1:0]     s_first_reg,
    input  logic [svm_pkg::DATA_W-1:0]    s_first_imm,
    input  logic [svm_pkg::SEL_W-1:0]     s_second_reg,
    input  logic [svm_pkg::DATA_W-1:0]    s_second_imm,
    input  logic                          cfg_wr_en,
    input  logic [svm_pkg::EP_W-1:0]      cfg_wr_data,
    input  svm_pkg::cmd_t                 cmd,
    output svm_pkg::status_t              status,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [svm_pkg::DATA_W-1:0]    m_next_ip,
    output logic [svm_pkg::DATA_W-1:0]    m_stack_index,
    output logic [svm_pkg::DATA_W-1:0]    m_top_value,
    output logic                          m_halted,
    output logic                          m_fault
);

    localparam int unsigned W  = svm_pkg::DATA_W;
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned HW = W / 2;

    // latched instruction
    logic [svm_pkg::OP_W-1:0]  op_reg;
    logic [svm_pkg::SEL_W-1:0] s1_reg;
    logic [svm_pkg::SEL_W-1:0] s2_reg;
    logic [W-1:0]              imm1_reg;
    logic [W-1:0]              imm2_reg;

    // architectural state
    logic [W-1:0] rf_reg [svm_pkg::RF_SLOTS];
    logic [W-1:0] sp_reg;
    logic [W-1:0] bp_reg;
    logic         halt_reg;
    logic         fault_reg;
    logic [W-1:0] mem [STACK_DEPTH];

    // working registers
    logic [W-1:0]  x_reg;
    logic [W-1:0]  y_reg;
    logic [W-1:0]  rdata_reg;
    logic          rd_oor_reg;
    logic [W-1:0]  p0_reg;
    logic [HW-1:0] cross_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          clr_done_reg;
    logic          m_valid_reg;

    logic [W-1:0]  rdata_v;
    logic [W-1:0]  sp1;
    logic [W-1:0]  rd_addr;
    logic [W-1:0]  wr_addr;
    logic [W-1:0]  wdata;
    logic [W-1:0]  opw_val;
    logic [W-1:0]  op1_val;
    logic [W-1:0]  op2_val;
    logic [W-1:0]  alu_res;
    logic [W-1:0]  mul_res;
    logic [HW-1:0] mul_a;
    logic [HW-1:0] mul_b;
    logic [W-1:0]  prod;
    logic          rd_in;
    logic          wr_in;
    logic          div_op;
    logic          div_done;
    logic [W-1:0]  div_quo;
    logic [W-1:0]  div_rem;

    assign rdata_v = rd_oor_reg ? '0 : rdata_reg;
    assign sp1     = sp_reg + W'(1);

    // stack address and data selection
    always_comb begin
        case (cmd.rd_addr)
            svm_pkg::ADDR_SP:    rd_addr = sp_reg;
            svm_pkg::ADDR_SP1:   rd_addr = sp1;
            svm_pkg::ADDR_RDATA: rd_addr = rdata_v;
            default:             rd_addr = x_reg;
        endcase
        case (cmd.wr_addr)
            svm_pkg::ADDR_SP:    wr_addr = sp_reg;
            svm_pkg::ADDR_SP1:   wr_addr = sp1;
            svm_pkg::ADDR_RDATA: wr_addr = rdata_v;
            default:             wr_addr = x_reg;
        endcase
        case (cmd.wr_data)
            svm_pkg::WD_X:     wdata = x_reg;
            svm_pkg::WD_RDATA: wdata = rdata_v;
            default:           wdata = alu_res;
        endcase
        case (cmd.opw_data)
            svm_pkg::OW_RDATA: opw_val = rdata_v;
            svm_pkg::OW_Y:     opw_val = y_reg;
            default:           opw_val = alu_res;
        endcase
    end

    assign rd_in = rd_addr < W'(STACK_DEPTH);
    assign wr_in = wr_addr < W'(STACK_DEPTH);

    // operand read
    always_comb begin
        op1_val = '0;
        if (s1_reg < REG_COUNT) begin
            op1_val = rf_reg[s1_reg];
        end else if (s1_reg == svm_pkg::SEL_SP) begin
            op1_val = sp_reg;
        end else if (s1_reg == svm_pkg::SEL_BP) begin
            op1_val = bp_reg;
        end else if (s1_reg == svm_pkg::SEL_IMM) begin
            op1_val = imm1_reg;
        end
        op2_val = '0;
        if (s2_reg < REG_COUNT) begin
            op2_val = rf_reg[s2_reg];
        end else if (s2_reg == svm_pkg::SEL_SP) begin
            op2_val = sp_reg;
        end else if (s2_reg == svm_pkg::SEL_BP) begin
            op2_val = bp_reg;
        end else if (s2_reg == svm_pkg::SEL_IMM) begin
            op2_val = imm2_reg;
        end
    end

    // shared 32x32 multiplier stepped over the LL, LH and HL partial products
    always_comb begin
        case (cmd.mul_step)
            svm_pkg::MUL_LH: begin
                mul_a = x_reg[HW-1:0];
                mul_b = y_reg[W-1:HW];
            end
            svm_pkg::MUL_HL: begin
                mul_a = x_reg[W-1:HW];
                mul_b = y_reg[HW-1:0];
            end
            default: begin
                mul_a = x_reg[HW-1:0];
                mul_b = y_reg[HW-1:0];
            end
        endcase
    end

    assign prod    = W'(mul_a) * W'(mul_b);
    assign mul_res = p0_reg + {cross_reg, {HW{1'b0}}};

    always_ff @(posedge aclk) begin
        case (cmd.mul_step)
            svm_pkg::MUL_LL: p0_reg <= prod;
            svm_pkg::MUL_LH: cross_reg <= prod[HW-1:0];
            svm_pkg::MUL_HL: cross_reg <= cross_reg + prod[HW-1:0];
            default: ;
        endcase
    end

    svm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (x_reg),
        .divisor   (y_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign div_op = (op_reg == svm_pkg::OP_DIV) || (op_reg == svm_pkg::OP_REM);

    // alu
    always_comb begin
        case (op_reg)
            svm_pkg::OP_ADD: alu_res = x_reg + y_reg;
            svm_pkg::OP_SUB: alu_res = x_reg - y_reg;
            svm_pkg::OP_DIV: alu_res = (y_reg == '0) ? '0 : div_quo;
            svm_pkg::OP_MUL: alu_res = mul_res;
            svm_pkg::OP_REM: alu_res = (y_reg == '0) ? '0 : div_rem;
            svm_pkg::OP_AND: alu_res = x_reg & y_reg;
            svm_pkg::OP_OR:  alu_res = x_reg | y_reg;
            svm_pkg::OP_XOR: alu_res = x_reg ^ y_reg;
            svm_pkg::OP_NOT: alu_res = W'(x_reg == '0);
            svm_pkg::OP_CMP: alu_res = W'(x_reg == y_reg);
            default:         alu_res = W'($signed(x_reg) > $signed(y_reg));
        endcase
    end

    // instruction latch and working registers
    always_ff @(posedge aclk) begin
        if (cmd.ld_instr) begin
            op_reg   <= s_op;
            s1_reg   <= s_first_reg;
            s2_reg   <= s_second_reg;
            imm1_reg <= s_first_imm;
            imm2_reg <= s_second_imm;
        end
        if (cmd.ld_x_op1) begin
            x_reg <= op1_val;
        end else if (cmd.ld_x_rdata) begin
            x_reg <= rdata_v;
        end
        if (cmd.ld_y_op2) begin
            y_reg <= op2_val;
        end else if (cmd.ld_y_rdata) begin
            y_reg <= rdata_v;
        end
    end

    // register file, ip and pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < svm_pkg::RF_SLOTS; i++) begin
                rf_reg[i] <= '0;
            end
            sp_reg   <= W'(STACK_DEPTH - 1);
            bp_reg   <= W'(STACK_DEPTH - 1);
            halt_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                rf_reg[IP_INDEX] <= {{(W - svm_pkg::EP_W){1'b0}}, cfg_wr_data};
            end else if (cmd.jump) begin
                rf_reg[IP_INDEX] <= x_reg - W'(1);
            end else if (cmd.ip_inc) begin
                rf_reg[IP_INDEX] <= rf_reg[IP_INDEX] + W'(1);
            end
            if (cmd.opw && (s1_reg < REG_COUNT)) begin
                rf_reg[s1_reg] <= opw_val;
            end
            if (cmd.sp_dec) begin
                sp_reg <= sp_reg - W'(1);
            end else if (cmd.sp_inc) begin
                sp_reg <= sp1;
            end else if (cmd.opw && (s1_reg == svm_pkg::SEL_SP)) begin
                sp_reg <= opw_val;
            end
            if (cmd.opw && (s1_reg == svm_pkg::SEL_BP)) begin
                bp_reg <= opw_val;
            end
            if (cmd.set_halt) begin
                halt_reg <= 1'b1;
            end
        end
    end

    // per-step fault
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_reg <= 1'b0;
        end else if (cmd.clr_fault) begin
            fault_reg <= 1'b0;
        end else if ((cmd.mem_rd && cmd.rd_fault_en && !rd_in) || (cmd.mem_wr && !wr_in)
                     || (cmd.alu_wb && div_op && (y_reg == '0))) begin
            fault_reg <= 1'b1;
        end
    end

    // clearing pass over the stack after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clr_done_reg <= 1'b0;
        end else if (!clr_done_reg) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(STACK_DEPTH - 1)) begin
                clr_done_reg <= 1'b1;
            end
        end
    end

    // stack memory
    always_ff @(posedge aclk) begin
        if (!clr_done_reg) begin
            mem[clr_cnt_reg] <= '0;
        end else if (cmd.mem_wr && wr_in) begin
            mem[wr_addr[AW-1:0]] <= wdata;
        end
        if (cmd.mem_rd) begin
            rdata_reg  <= mem[rd_addr[AW-1:0]];
            rd_oor_reg <= !rd_in;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.ld_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_out) begin
            m_next_ip     <= rf_reg[IP_INDEX];
            m_stack_index <= sp_reg;
            m_top_value   <= rdata_v;
            m_halted      <= halt_reg;
            m_fault       <= fault_reg;
        end
    end

    assign m_valid = m_valid_reg;

    assign status.clear_done = clr_done_reg;
    assign status.halted     = halt_reg;
    assign status.cr_zero    = (rf_reg[CR_INDEX] == '0);
    assign status.y_zero     = (y_reg == '0);
    assign status.div_done   = div_done;
    assign status.out_free   = !m_valid_reg || m_ready;

endmodule

// ----- sv/svm_ctrl.sv -----
// controller: sequences each instruction as datapath micro-steps
module svm_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [svm_pkg::OP_W-1:0]   s_op,
    input  logic [svm_pkg::PC_W-1:0]   s_param_count,
    input  svm_pkg::status_t           status,
    output svm_pkg::cmd_t              cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DEC, ST_P1, ST_P2, ST_P3, ST_EXEC, ST_MUL0, ST_MUL1, ST_MUL2,
        ST_DIVW, ST_WB, ST_FIN, ST_TOP, ST_OUT
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [svm_pkg::OP_W-1:0] op_reg;
    logic [svm_pkg::PC_W-1:0] pc_reg;

    assign s_ready = (state_reg == ST_IDLE) && status.clear_done;

    // state and latched opcode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= '0;
            pc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (s_valid && s_ready) begin
                op_reg <= s_op;
                pc_reg <= s_param_count;
            end
        end
    end

    // micro-step decode
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.ld_instr = 1'b1;
                    state_next   = ST_DEC;
                end
            end
            ST_DEC: begin
                cmd.clr_fault = 1'b1;
                state_next    = status.halted ? ST_TOP : ST_P1;
            end
            ST_P1: begin
                state_next = ST_FIN;
                case (op_reg)
                    svm_pkg::OP_DEREF: begin
                        cmd.mem_rd      = 1'b1;
                        cmd.rd_fault_en = 1'b1;
                        cmd.rd_addr     = svm_pkg::ADDR_SP;
                        state_next      = ST_P2;
                    end
                    svm_pkg::OP_JMP, svm_pkg::OP_JN: begin
                        cmd.ld_x_op1 = 1'b1;
                        state_next   = ST_P2;
                    end
                    svm_pkg::OP_PUSH: begin
                        cmd.sp_dec = 1'b1;
                        state_next = ST_P2;
                    end
                    svm_pkg::OP_POP: begin
                        if (pc_reg == svm_pkg::PC_ONE) begin
                            cmd.mem_rd      = 1'b1;
                            cmd.rd_fault_en = 1'b1;
                            cmd.rd_addr     = svm_pkg::ADDR_SP;
                        end
                        state_next = ST_P2;
                    end
                    svm_pkg::OP_MOV: begin
                        if (pc_reg == svm_pkg::PC_TWO) begin
                            cmd.ld_y_op2 = 1'b1;
                            state_next   = ST_P2;
                        end else if (pc_reg == svm_pkg::PC_STACK) begin
                            cmd.mem_rd      = 1'b1;
                            cmd.rd_fault_en = 1'b1;
                            cmd.rd_addr     = svm_pkg::ADDR_SP1;
                            state_next      = ST_P2;
                        end
                    end
                    svm_pkg::OP_EXIT: begin
                        cmd.set_halt = 1'b1;
                        state_next   = ST_TOP;
                    end
                    svm_pkg::OP_ADD, svm_pkg::OP_SUB, svm_pkg::OP_DIV, svm_pkg::OP_MUL,
                    svm_pkg::OP_REM, svm_pkg::OP_AND, svm_pkg::OP_OR, svm_pkg::OP_XOR,
                    svm_pkg::OP_NOT, svm_pkg::OP_CMP, svm_pkg::OP_CMPB: begin
                        if (pc_reg == svm_pkg::PC_STACK) begin
                            cmd.mem_rd      = 1'b1;
                            cmd.rd_fault_en = 1'b1;
                            cmd.rd_addr     = svm_pkg::ADDR_SP1;
                            state_next      = ST_P2;
                        end else if (pc_reg == svm_pkg::PC_TWO) begin
                            cmd.ld_x_op1 = 1'b1;
                            cmd.ld_y_op2 = 1'b1;
                            state_next   = ST_EXEC;
                        end
                    end
                    default: ;
                endcase
            end
            ST_P2: begin
                state_next = ST_FIN;
                case (op_reg)
                    svm_pkg::OP_DEREF: begin
                        cmd.mem_rd      = 1'b1;
                        cmd.rd_fault_en = 1'b1;
                        cmd.rd_addr     = svm_pkg::ADDR_RDATA;
                        state_next      = ST_P3;
                    end
                    svm_pkg::OP_JMP: begin
                        cmd.jump = 1'b1;
                    end
                    svm_pkg::OP_JN: begin
                        cmd.jump = status.cr_zero;
                    end
                    svm_pkg::OP_PUSH: begin
                        cmd.ld_x_op1 = 1'b1;
                        state_next   = ST_P3;
                    end
                    svm_pkg::OP_POP: begin
                        if (pc_reg == svm_pkg::PC_ONE) begin
                            cmd.opw      = 1'b1;
                            cmd.opw_data = svm_pkg::OW_RDATA;
                        end
                        state_next = ST_P3;
                    end
                    svm_pkg::OP_MOV: begin
                        if (pc_reg == svm_pkg::PC_TWO) begin
                            cmd.opw      = 1'b1;
                            cmd.opw_data = svm_pkg::OW_Y;
                        end else begin
                            cmd.mem_rd      = 1'b1;
                            cmd.rd_fault_en = 1'b1;
                            cmd.rd_addr     = svm_pkg::ADDR_SP;
                            cmd.ld_x_rdata  = 1'b1;
                            state_next      = ST_P3;
                        end
                    end
                    default: begin
                        // stack-form alu: second read, keep first word
                        cmd.mem_rd      = 1'b1;
                        cmd.rd_fault_en = 1'b1;
                        cmd.rd_addr     = svm_pkg::ADDR_SP;
                        cmd.ld_x_rdata  = 1'b1;
                        state_next      = ST_P3;
                    end
                endcase
            end
            ST_P3: begin
                state_next = ST_FIN;
                case (op_reg)
                    svm_pkg::OP_DEREF: begin
                        cmd.mem_wr  = 1'b1;
                        cmd.wr_addr = svm_pkg::ADDR_SP;
                        cmd.wr_data = svm_pkg::WD_RDATA;
                    end
                    svm_pkg::OP_PUSH: begin
                        if (pc_reg == svm_pkg::PC_ONE) begin
                            cmd.mem_wr  = 1'b1;
                            cmd.wr_addr = svm_pkg::ADDR_SP;
                            cmd.wr_data = svm_pkg::WD_X;
                        end
                    end
                    svm_pkg::OP_POP: begin
                        cmd.sp_inc = 1'b1;
                    end
                    svm_pkg::OP_MOV: begin
                        cmd.mem_wr  = 1'b1;
                        cmd.wr_addr = svm_pkg::ADDR_X;
                        cmd.wr_data = svm_pkg::WD_RDATA;
                        cmd.sp_inc  = 1'b1;
                    end
                    default: begin
                        cmd.ld_y_rdata = 1'b1;
                        state_next     = ST_EXEC;
                    end
                endcase
            end
            ST_EXEC: begin
                if (op_reg == svm_pkg::OP_MUL) begin
                    state_next = ST_MUL0;
                end else if (((op_reg == svm_pkg::OP_DIV) || (op_reg == svm_pkg::OP_REM))
                             && !status.y_zero) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVW;
                end else begin
                    state_next = ST_WB;
                end
            end
            ST_MUL0: begin
                cmd.mul_step = svm_pkg::MUL_LL;
                state_next   = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul_step = svm_pkg::MUL_LH;
                state_next   = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul_step = svm_pkg::MUL_HL;
                state_next   = ST_WB;
            end
            ST_DIVW: begin
                if (status.div_done) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                cmd.alu_wb = 1'b1;
                if (pc_reg == svm_pkg::PC_STACK) begin
                    cmd.mem_wr  = 1'b1;
                    cmd.wr_addr = svm_pkg::ADDR_SP1;
                    cmd.wr_data = svm_pkg::WD_ALU;
                    cmd.sp_inc  = 1'b1;
                end else begin
                    cmd.opw      = 1'b1;
                    cmd.opw_data = svm_pkg::OW_ALU;
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.ip_inc = 1'b1;
                state_next = ST_TOP;
            end
            ST_TOP: begin
                // top-of-stack read for the result, no fault
                cmd.mem_rd  = 1'b1;
                cmd.rd_addr = svm_pkg::ADDR_SP;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.ld_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- dv/stack_register_vm_execute_checker.sv -----
// result predictor and scoreboard for the stack register vm execute unit
module stack_register_vm_execute_checker #(
    parameter int STACK_DEPTH = 1024,
    parameter int REG_COUNT   = 20,
    parameter int IP_INDEX    = 0,
    parameter int CR_INDEX    = 1
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [4:0]  s_op,
    input  logic [1:0]  s_param_count,
    input  logic [4:0]  s_first_reg,
    input  logic [63:0] s_first_imm,
    input  logic [4:0]  s_second_reg,
    input  logic [63:0] s_second_imm,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_next_ip,
    input  logic [63:0] m_stack_index,
    input  logic [63:0] m_top_value,
    input  logic        m_halted,
    input  logic        m_fault,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REG_SLOTS = 20;

    typedef struct packed {
        logic [63:0] next_ip;
        logic [63:0] stack_index;
        logic [63:0] top_value;
        logic        halted;
        logic        fault;
    } vm_state_t;

    // machine state mirror
    logic [63:0] regs [REG_SLOTS];
    logic [63:0] words [STACK_DEPTH];
    logic [63:0] sp;
    logic [63:0] bp;
    bit          halt;
    bit          flt;
    vm_state_t   state_q[$];

    function automatic logic [63:0] word_rd(logic [63:0] a);
        if (a < 64'(STACK_DEPTH)) return words[a];
        flt = 1;
        return '0;
    endfunction

    function automatic void word_wr(logic [63:0] a, logic [63:0] v);
        if (a < 64'(STACK_DEPTH)) words[a] = v;
        else flt = 1;
    endfunction

    function automatic logic [63:0] operand(logic [4:0] sel, logic [63:0] imm);
        if (sel < REG_COUNT && sel < REG_SLOTS) return regs[sel];
        if (sel == svm_pkg::SEL_SP) return sp;
        if (sel == svm_pkg::SEL_BP) return bp;
        if (sel == svm_pkg::SEL_IMM) return imm;
        return '0;
    endfunction

    function automatic void operand_wr(logic [4:0] sel, logic [63:0] v);
        if (sel < REG_COUNT && sel < REG_SLOTS) regs[sel] = v;
        else if (sel == svm_pkg::SEL_SP) sp = v;
        else if (sel == svm_pkg::SEL_BP) bp = v;
    endfunction

    function automatic logic [63:0] alu(logic [4:0] op, logic [63:0] a, logic [63:0] b);
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        logic [63:0] min_val;
        sa = a;
        sb = b;
        min_val = {1'b1, 63'd0};
        case (op)
            svm_pkg::OP_ADD: return a + b;
            svm_pkg::OP_SUB: return a - b;
            svm_pkg::OP_DIV: begin
                if (b == '0) begin
                    flt = 1;
                    return '0;
                end
                if (a == min_val && b == '1) return a;
                return sa / sb;
            end
            svm_pkg::OP_MUL: return a * b;
            svm_pkg::OP_REM: begin
                if (b == '0) begin
                    flt = 1;
                    return '0;
                end
                if (a == min_val && b == '1) return '0;
                return sa % sb;
            end
            svm_pkg::OP_AND: return a & b;
            svm_pkg::OP_OR:  return a | b;
            svm_pkg::OP_XOR: return a ^ b;
            svm_pkg::OP_NOT: return (a == '0) ? 64'd1 : 64'd0;
            svm_pkg::OP_CMP: return (a == b) ? 64'd1 : 64'd0;
            default: return (sa > sb) ? 64'd1 : 64'd0;
        endcase
    endfunction

    // execute one instruction against the mirror and queue the resulting state
    function automatic void execute(logic [4:0] op, logic [1:0] pc, logic [4:0] s1,
                                    logic [63:0] i1, logic [4:0] s2, logic [63:0] i2);
        logic [63:0] t;
        logic [63:0] a;
        bit advance;
        vm_state_t r;
        flt = 0;
        advance = 1;
        if (!halt) begin
            case (op)
                svm_pkg::OP_DEREF: begin
                    t = word_rd(sp);
                    t = word_rd(t);
                    word_wr(sp, t);
                end
                svm_pkg::OP_JMP: regs[IP_INDEX] = operand(s1, i1) - 64'd1;
                svm_pkg::OP_JN: begin
                    if (regs[CR_INDEX] == '0) regs[IP_INDEX] = operand(s1, i1) - 64'd1;
                end
                svm_pkg::OP_PUSH: begin
                    sp = sp - 64'd1;
                    if (pc == svm_pkg::PC_ONE) word_wr(sp, operand(s1, i1));
                end
                svm_pkg::OP_POP: begin
                    if (pc == svm_pkg::PC_ONE) operand_wr(s1, word_rd(sp));
                    sp = sp + 64'd1;
                end
                svm_pkg::OP_MOV: begin
                    if (pc == svm_pkg::PC_TWO) begin
                        operand_wr(s1, operand(s2, i2));
                    end else if (pc == svm_pkg::PC_STACK) begin
                        a = word_rd(sp + 64'd1);
                        word_wr(a, word_rd(sp));
                        sp = sp + 64'd1;
                    end
                end
                svm_pkg::OP_EXIT: begin
                    halt = 1;
                    advance = 0;
                end
                default: begin
                    if (op >= svm_pkg::OP_ADD && op <= svm_pkg::OP_CMPB) begin
                        if (pc == svm_pkg::PC_STACK) begin
                            a = word_rd(sp + 64'd1);
                            t = word_rd(sp);
                            word_wr(sp + 64'd1, alu(op, a, t));
                            sp = sp + 64'd1;
                        end else if (pc == svm_pkg::PC_TWO) begin
                            t = alu(op, operand(s1, i1), operand(s2, i2));
                            operand_wr(s1, t);
                        end
                    end
                end
            endcase
            if (advance) regs[IP_INDEX] = regs[IP_INDEX] + 64'd1;
        end
        r.next_ip     = regs[IP_INDEX];
        r.stack_index = sp;
        r.top_value   = (sp < 64'(STACK_DEPTH)) ? words[sp] : '0;
        r.halted      = halt;
        r.fault       = flt;
        state_q.push_back(r);
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        vm_state_t e;
        if (!aresetn) begin
            foreach (regs[i]) regs[i] = '0;
            foreach (words[i]) words[i] = '0;
            sp     = 64'(STACK_DEPTH - 1);
            bp     = 64'(STACK_DEPTH - 1);
            halt   = 0;
            errors = 0;
            state_q.delete();
        end else begin
            // entry point write reloads the instruction pointer
            if (cfg_wr_en) regs[IP_INDEX] = {48'd0, cfg_wr_data};
            // result transfer: compare against the oldest prediction
            if (m_valid && m_ready) begin
                if (state_q.size() == 0) begin
                    errors++;
                    $display("%0t: result with no prediction, actual ip %h sp %h",
                             $time, m_next_ip, m_stack_index);
                end else begin
                    e = state_q.pop_front();
                    check_field("next_ip", e.next_ip, m_next_ip);
                    check_field("stack_index", e.stack_index, m_stack_index);
                    check_field("top_value", e.top_value, m_top_value);
                    check_field("halted", 64'(e.halted), 64'(m_halted));
                    check_field("fault", 64'(e.fault), 64'(m_fault));
                end
            end
            // instruction transfer
            if (s_valid && s_ready)
                execute(s_op, s_param_count, s_first_reg, s_first_imm,
                        s_second_reg, s_second_imm);
        end
        pending = state_q.size();
    end

endmodule

// ----- dv/stack_register_vm_execute_unit_tb.sv -----
// testbench top: stimulus, receiver stalls and verdict for the vm execute unit
module stack_register_vm_execute_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [svm_pkg::SEL_W-1:0] SEL_NONE = 5'd25;
    localparam logic [63:0] MIN_VAL = {1'b1, 63'd0};
    localparam logic [63:0] MAX_VAL = {1'b0, {63{1'b1}}};

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [4:0]  s_op = '0;
    logic [1:0]  s_param_count = '0;
    logic [4:0]  s_first_reg = '0;
    logic [63:0] s_first_imm = '0;
    logic [4:0]  s_second_reg = '0;
    logic [63:0] s_second_imm = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [63:0] m_next_ip;
    logic [63:0] m_stack_index;
    logic [63:0] m_top_value;
    logic        m_halted;
    logic        m_fault;
    int          errors;
    int          pending;
    bit          long_hold;
    int          burst_left;
    int          stall_pct;

    always #5 aclk = ~aclk;

    stack_register_vm_execute_unit dut (.*);

    stack_register_vm_execute_checker checker_i (.*);

    // receiver: stall density changes at random intervals, one long hold-off on request
    initial begin
        int cnt;
        cnt = 0;
        stall_pct = 0;
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                long_hold = 0;
            end
            if (cnt == 0) begin
                cnt = $urandom_range(20, 80);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            cnt--;
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // one instruction transfer, called at a rising edge, returns at the transfer edge or after an idle gap
    task automatic send(logic [4:0] op, logic [1:0] pc, logic [4:0] s1, logic [63:0] i1,
                        logic [4:0] s2, logic [63:0] i2);
        s_valid       <= 1'b1;
        s_op          <= op;
        s_param_count <= pc;
        s_first_reg   <= s1;
        s_first_imm   <= i1;
        s_second_reg  <= s2;
        s_second_imm  <= i2;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 20);
        end
    endtask

    // stop sending, drain outstanding results, then write the entry point
    task automatic write_entry(logic [15:0] v);
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        @(posedge aclk);
        repeat (10) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 64'($urandom_range(0, 1023));
            4: return MIN_VAL;
            5: return MAX_VAL;
            6: return '1;
            7: return 64'($urandom_range(0, 3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [4:0] pick_sel();
        case ($urandom_range(0, 19))
            0: return svm_pkg::SEL_SP;
            1: return svm_pkg::SEL_BP;
            2: return 5'($urandom_range(23, 31));
            3, 4, 5: return svm_pkg::SEL_IMM;
            default: return 5'($urandom_range(0, 19));
        endcase
    endfunction

    task automatic random_item();
        logic [4:0]  op;
        logic [1:0]  pc;
        logic [4:0]  s1;
        logic [4:0]  s2;
        logic [63:0] i1;
        logic [63:0] i2;
        op = ($urandom_range(0, 29) == 0) ? 5'($urandom_range(19, 31))
                                          : 5'($urandom_range(0, 18));
        // exit only at the end of the run
        if (op == svm_pkg::OP_EXIT) op = svm_pkg::OP_NOP;
        pc = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        s1 = pick_sel();
        s2 = pick_sel();
        i1 = pick_value();
        i2 = pick_value();
        // keep most pointer writes inside the stack
        if (s1 == svm_pkg::SEL_SP && $urandom_range(0, 3) != 0) begin
            op = svm_pkg::OP_MOV;
            pc = svm_pkg::PC_TWO;
            s2 = svm_pkg::SEL_IMM;
            i2 = 64'($urandom_range(2, 1023));
        end
        if (op == svm_pkg::OP_PUSH && $urandom_range(0, 1) == 0) pc = svm_pkg::PC_ONE;
        send(op, pc, s1, i1, s2, i2);
    endtask

    task automatic directed_items();
        // push extremes, then stack-form arithmetic, special divides, memory moves, jumps and an invalid opcode
        send(svm_pkg::OP_PUSH, svm_pkg::PC_ONE, svm_pkg::SEL_IMM, MAX_VAL, 5'd0, '0);
        send(svm_pkg::OP_PUSH, svm_pkg::PC_ONE, svm_pkg::SEL_IMM, MIN_VAL, 5'd0, '0);
        send(svm_pkg::OP_ADD, svm_pkg::PC_STACK, 5'd0, '0, 5'd0, '0);
        send(svm_pkg::OP_PUSH, svm_pkg::PC_ONE, svm_pkg::SEL_IMM, MIN_VAL, 5'd0, '0);
        send(svm_pkg::OP_PUSH, svm_pkg::PC_ONE, svm_pkg::SEL_IMM, '1, 5'd0, '0);
        send(svm_pkg::OP_DIV, svm_pkg::PC_STACK, 5'd0, '0, 5'd0, '0);
        send(svm_pkg::OP_MOV, svm_pkg::PC_TWO, 5'd3, '0, svm_pkg::SEL_IMM, MIN_VAL);
        send(svm_pkg::OP_REM, svm_pkg::PC_TWO, 5'd3, '0, svm_pkg::SEL_IMM, '1);
        send(svm_pkg::OP_DIV, svm_pkg::PC_TWO, 5'd4, '0, svm_pkg::SEL_IMM, '0);
        send(svm_pkg::OP_REM, svm_pkg::PC_TWO, svm_pkg::SEL_IMM, 64'd7,
             svm_pkg::SEL_IMM, '0);
        send(svm_pkg::OP_PUSH, svm_pkg::PC_ONE, svm_pkg::SEL_IMM, 64'd1000, 5'd0, '0);
        send(svm_pkg::OP_DEREF, svm_pkg::PC_STACK, 5'd0, '0, 5'd0, '0);
        send(svm_pkg::OP_PUSH, svm_pkg::PC_ONE, svm_pkg::SEL_IMM, 64'd1010, 5'd0, '0);
        send(svm_pkg::OP_PUSH, svm_pkg::PC_ONE, svm_pkg::SEL_IMM, 64'h55, 5'd0, '0);
        send(svm_pkg::OP_MOV, svm_pkg::PC_STACK, 5'd0, '0, 5'd0, '0);
        send(svm_pkg::OP_POP, svm_pkg::PC_ONE, 5'd19, '0, 5'd0, '0);
        send(svm_pkg::OP_CMPB, svm_pkg::PC_TWO, 5'd19, '0, SEL_NONE, '0);
        send(svm_pkg::OP_NOT, svm_pkg::PC_TWO, 5'd5, '0, 5'd0, '0);
        send(svm_pkg::OP_JN, svm_pkg::PC_ONE, svm_pkg::SEL_IMM, 64'd500, 5'd0, '0);
        send(svm_pkg::OP_MOV, svm_pkg::PC_TWO, 5'd1, '0, svm_pkg::SEL_IMM, 64'd1);
        send(svm_pkg::OP_JN, svm_pkg::PC_ONE, svm_pkg::SEL_IMM, 64'd9, 5'd0, '0);
        send(svm_pkg::OP_JMP, svm_pkg::PC_ONE, svm_pkg::SEL_IMM, MIN_VAL, 5'd0, '0);
        send(5'd31, 2'd3, 5'd31, '1, 5'd31, '1);
        // pointer past the stack: reads give zero, writes are dropped
        send(svm_pkg::OP_MOV, svm_pkg::PC_TWO, svm_pkg::SEL_SP, '0,
             svm_pkg::SEL_IMM, 64'd1024);
        send(svm_pkg::OP_POP, svm_pkg::PC_ONE, 5'd2, '0, 5'd0, '0);
        send(svm_pkg::OP_PUSH, svm_pkg::PC_ONE, svm_pkg::SEL_BP, '0, 5'd0, '0);
        send(svm_pkg::OP_MOV, svm_pkg::PC_TWO, svm_pkg::SEL_SP, '0, svm_pkg::SEL_BP, '0);
    endtask

    // the run is cut off if the results stop coming
    initial begin
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        long_hold  = 0;
        burst_left = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_entry(16'hFFFF);
        directed_items();
        // random phases under different entry points
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_entry(16'h0000);
                1: write_entry(16'h0001);
                2: write_entry(16'hFFFF);
                default: write_entry(16'($urandom_range(0, 65535)));
            endcase
            for (int n = 0; n < 430; n++) begin
                if (ph == 1 && n == 100) long_hold = 1;
                if (n % 50 == 0)
                    send(svm_pkg::OP_MOV, svm_pkg::PC_TWO, svm_pkg::SEL_SP, '0,
                         svm_pkg::SEL_IMM, 64'($urandom_range(16, 1023)));
                random_item();
            end
        end
        // exit, then a few instructions that must change nothing
        send(svm_pkg::OP_EXIT, svm_pkg::PC_STACK, 5'd0, '0, 5'd0, '0);
        repeat (6) random_item();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
